FILE: rtl/cucc_pkg.sv
package cucc_pkg;

	localparam int unsigned MAX_TOTAL_BYTES = 1048576;
	localparam int unsigned MAX_CHUNK_BYTES = 8184;
	localparam int unsigned COUNT_W = 21;
	localparam int unsigned LEN_W = 13;
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

	localparam logic [2:0] CMD_RESET = 3'd0;
	localparam logic [2:0] CMD_OPEN = 3'd1;
	localparam logic [2:0] CMD_HEADER = 3'd2;
	localparam logic [2:0] CMD_DATA = 3'd3;
	localparam logic [2:0] CMD_COMMIT = 3'd4;

	typedef enum logic [2:0] {
		OP_RESET,
		OP_OPEN,
		OP_HEADER,
		OP_DATA,
		OP_COMMIT,
		OP_UNUSED
	} op_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0,
		ST_NO_SESSION = 4'd1,
		ST_BAD_OPEN = 4'd2,
		ST_BAD_INDEX = 4'd3,
		ST_BAD_LENGTH = 4'd4,
		ST_OVERFLOW = 4'd5,
		ST_COUNT = 4'd6,
		ST_TAG = 4'd7,
		ST_CRC = 4'd8,
		ST_SEQUENCE = 4'd9
	} status_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic signed [31:0] total_bytes;
		logic signed [31:0] chunk_size;
		logic signed [31:0] session_tag;
		logic signed [31:0] chunk_index;
		logic [31:0] chunk_len;
		logic [31:0] expected_crc;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		status_t status;
		logic byte_valid;
		logic [7:0] byte_out;
		logic committed;
		logic [COUNT_W-1:0] received_count;
	} rsp_t;

	typedef struct packed {
		op_t op;
		logic open_ok;
		logic total_hi_zero;
		logic [COUNT_W-1:0] total_lo;
		logic [31:0] tag;
		logic idx_hi_zero;
		logic [COUNT_W-1:0] idx_lo;
		logic len_ok;
		logic [LEN_W-1:0] len_lo;
		logic [31:0] ecrc;
		logic [7:0] data;
	} item_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'b0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: rtl/cucc_front.sv
module cucc_front (
	input  cucc_pkg::req_t  req_data,
	output cucc_pkg::item_t item
);
	import cucc_pkg::*;

	logic [31:0] total_u;
	logic [31:0] csize_u;
	logic [31:0] idx_u;

	assign total_u = $unsigned(req_data.total_bytes);
	assign csize_u = $unsigned(req_data.chunk_size);
	assign idx_u = $unsigned(req_data.chunk_index);

	always_comb begin
		item = '0;
		case (req_data.cmd)
			CMD_RESET: item.op = OP_RESET;
			CMD_OPEN: item.op = OP_OPEN;
			CMD_HEADER: item.op = OP_HEADER;
			CMD_DATA: item.op = OP_DATA;
			CMD_COMMIT: item.op = OP_COMMIT;
			default: item.op = OP_UNUSED;
		endcase
		item.open_ok = (total_u != 32'd0) && (total_u <= MAX_TOTAL_BYTES)
			&& (csize_u != 32'd0) && (csize_u <= MAX_CHUNK_BYTES);
		item.total_hi_zero = (total_u[31:COUNT_W] == '0);
		item.total_lo = total_u[COUNT_W-1:0];
		item.tag = $unsigned(req_data.session_tag);
		item.idx_hi_zero = (idx_u[31:COUNT_W] == '0);
		item.idx_lo = idx_u[COUNT_W-1:0];
		item.len_ok = (req_data.chunk_len != 32'd0) && (req_data.chunk_len <= MAX_CHUNK_BYTES);
		item.len_lo = req_data.chunk_len[LEN_W-1:0];
		item.ecrc = req_data.expected_crc;
		item.data = req_data.data_byte;
	end

endmodule

FILE: rtl/cucc_queue.sv
module cucc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cucc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output cucc_pkg::item_t head_item
);
	import cucc_pkg::*;

	item_t entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_item = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/cucc_back.sv
module cucc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  cucc_pkg::item_t head_item,
	output logic            pop,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output cucc_pkg::rsp_t  rsp_data
);
	import cucc_pkg::*;

	logic [COUNT_W-1:0] session_total_q, session_total_n;
	logic [COUNT_W-1:0] bytes_received_q, bytes_received_n;
	logic [COUNT_W-1:0] next_chunk_q, next_chunk_n;
	logic [LEN_W-1:0] bytes_pending_q, bytes_pending_n;
	logic [31:0] stored_tag_q, stored_tag_n;
	logic [31:0] running_crc_q, running_crc_n;
	logic out_valid_q;
	rsp_t out_q;
	rsp_t rsp_n;
	logic done;
	logic [COUNT_W-1:0] remaining;

	assign pop = head_valid && !(out_valid_q && rsp_stall);
	assign rsp_valid = out_valid_q;
	assign rsp_data = out_q;
	assign remaining = session_total_q - bytes_received_q;

	always_comb begin
		session_total_n = session_total_q;
		bytes_received_n = bytes_received_q;
		next_chunk_n = next_chunk_q;
		bytes_pending_n = bytes_pending_q;
		stored_tag_n = stored_tag_q;
		running_crc_n = running_crc_q;
		rsp_n = '0;
		rsp_n.status = ST_OK;
		done = 1'b0;
		case (head_item.op)
			OP_RESET: begin
				session_total_n = '0;
				bytes_received_n = '0;
				next_chunk_n = '0;
				bytes_pending_n = '0;
				stored_tag_n = '0;
				running_crc_n = CRC_ONES;
			end
			OP_OPEN: begin
				if (!head_item.open_ok) begin
					rsp_n.status = ST_BAD_OPEN;
				end else begin
					session_total_n = head_item.total_lo;
					bytes_received_n = '0;
					next_chunk_n = '0;
					bytes_pending_n = '0;
					stored_tag_n = head_item.tag;
					running_crc_n = CRC_ONES;
				end
			end
			OP_HEADER: begin
				if (session_total_q == '0) begin
					rsp_n.status = ST_NO_SESSION;
				end else if (bytes_pending_q != '0) begin
					rsp_n.status = ST_SEQUENCE;
				end else if (!(head_item.idx_hi_zero && head_item.idx_lo == next_chunk_q)) begin
					rsp_n.status = ST_BAD_INDEX;
				end else if (!head_item.len_ok) begin
					rsp_n.status = ST_BAD_LENGTH;
				end else if (COUNT_W'(head_item.len_lo) > remaining) begin
					rsp_n.status = ST_OVERFLOW;
				end else begin
					bytes_pending_n = head_item.len_lo;
					next_chunk_n = next_chunk_q + 1'b1;
				end
			end
			OP_DATA: begin
				if (session_total_q == '0) begin
					rsp_n.status = ST_NO_SESSION;
				end else if (bytes_pending_q == '0) begin
					rsp_n.status = ST_SEQUENCE;
				end else begin
					rsp_n.byte_valid = 1'b1;
					rsp_n.byte_out = head_item.data;
					running_crc_n = crc32_byte(running_crc_q, head_item.data);
					bytes_received_n = bytes_received_q + 1'b1;
					bytes_pending_n = bytes_pending_q - 1'b1;
				end
			end
			OP_COMMIT: begin
				if (session_total_q == '0) begin
					rsp_n.status = ST_NO_SESSION;
				end else if (bytes_pending_q != '0) begin
					rsp_n.status = ST_SEQUENCE;
				end else if (!(head_item.total_hi_zero && head_item.total_lo == session_total_q)
						|| bytes_received_q != session_total_q) begin
					rsp_n.status = ST_COUNT;
				end else if (head_item.tag != stored_tag_q) begin
					rsp_n.status = ST_TAG;
				end else if ((running_crc_q ^ CRC_ONES) != head_item.ecrc) begin
					rsp_n.status = ST_CRC;
				end else begin
					done = 1'b1;
					session_total_n = '0;
					bytes_received_n = '0;
					next_chunk_n = '0;
					bytes_pending_n = '0;
					stored_tag_n = '0;
					running_crc_n = CRC_ONES;
				end
			end
			default: begin
				rsp_n.status = ST_SEQUENCE;
			end
		endcase
		rsp_n.committed = done;
		rsp_n.received_count = done ? bytes_received_q : bytes_received_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_total_q <= '0;
			bytes_received_q <= '0;
			next_chunk_q <= '0;
			bytes_pending_q <= '0;
			stored_tag_q <= '0;
			running_crc_q <= CRC_ONES;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				session_total_q <= session_total_n;
				bytes_received_q <= bytes_received_n;
				next_chunk_q <= next_chunk_n;
				bytes_pending_q <= bytes_pending_n;
				stored_tag_q <= stored_tag_n;
				running_crc_q <= running_crc_n;
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= rsp_n;
		end
	end

endmodule

FILE: rtl/chunked_upload_crc_checker_core.sv
// Channel   Valid      Stall      Payload
// request   req_valid  req_stall  req_data (cucc_pkg::req_t)
// response  rsp_valid  rsp_stall  rsp_data (cucc_pkg::rsp_t)
//
// The block takes one request per cycle while req_stall is low and gives one
// response per request. A request passes through the queue, then the back end
// registers its response; the session update there, CRC byte step included,
// sets that rate. A two-entry queue separates decode from execution, so
// req_stall rises only when the queue is full behind a stalled response.
// Reset clears the session, the queue and the response valid flag.
module chunked_upload_crc_checker_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  cucc_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output cucc_pkg::rsp_t  rsp_data
);
	import cucc_pkg::*;

	item_t front_item;
	item_t head_item;
	logic q_full;
	logic head_valid;
	logic pop;

	assign req_stall = q_full;

	cucc_front u_front (
		.req_data (req_data),
		.item     (front_item)
	);

	cucc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (req_valid),
		.push_item  (front_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	cucc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data)
	);

endmodule

FILE: rtl/cucc_checker.sv
module cucc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input cucc_pkg::rsp_t rsp_data
);
	import cucc_pkg::*;

	// A stalled response must hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");

	// A forwarded byte only comes with a clean status.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.byte_valid |-> rsp_data.status == ST_OK && !rsp_data.committed)
		else $error("forwarded byte with error status or commit");

	// A commit only succeeds with a clean status.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.committed |-> rsp_data.status == ST_OK)
		else $error("commit flagged with error status");

	// No byte is forwarded without its valid flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.byte_valid |-> rsp_data.byte_out == 8'd0)
		else $error("byte output not zero without valid byte");

	// The request side only stalls while a response is waiting to be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid)
		else $error("request stalled with no response shown");

endmodule

bind chunked_upload_crc_checker_core cucc_checker u_cucc_checker (.*);
